[rtl/srsw_pkg.sv]
// Types and constants shared by the selective-repeat sender window.
package srsw_pkg;

  localparam int unsigned SEQ_BITS     = 6;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned MOD_W        = SEQ_BITS + 1;
  localparam int unsigned CNT_W        = $clog2(SEQ_BITS);
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [MOD_W-1:0] SEQ_SPACE = MOD_W'(1 << SEQ_BITS);

  localparam logic [CFG_W-1:0] SEQ_MODULUS_RST = CFG_W'(8);
  localparam logic [3:0]       WINDOW_SIZE_RST = 4'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b1;

  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [SEQ_BITS-1:0]     seq_in;
    logic                    checksum_ok;
    logic [PAYLOAD_BITS-1:0] payload_in;
  } srsw_item_t;

  typedef struct packed {
    logic                    accepted;
    logic                    window_full;
    logic                    tx_valid;
    logic [SEQ_BITS-1:0]     tx_seq;
    logic [PAYLOAD_BITS-1:0] tx_payload;
    logic                    timer_start;
    logic                    timer_stop;
    logic [SEQ_BITS-1:0]     timer_seq;
  } srsw_result_t;

endpackage

[rtl/selective_repeat_sender_window.sv]
// Selective-repeat ARQ sender window with a shared modulo unit and a small sequencer.
//
// A command beat is taken on start when busy is low. Each command yields exactly one
// result beat, shown on result_o for one cycle while done_o is high; the receiver
// cannot hold it off, and a new command may be started in that same cycle.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must
// write it only while idle, as the block does not enforce it. Sequence numbers are
// reduced modulo seq_modulus by a restoring remainder unit that handles one bit per
// cycle. A command reduces seq_in, forms its offset and executes; an accepted ack
// then slides the base past each acknowledged head slot (up to MAX_WINDOW), and a
// timeout that hits the window reads the payload store. After seq_modulus is
// rewritten, the first command also reduces the stored window base and next sequence
// number. The payload store is a small memory with a registered read port; its
// entries hold garbage until a send writes them. Reset empties the window, clears
// the acknowledge marks and returns the registers to modulus 8 and window 4.
module selective_repeat_sender_window #(
  parameter int unsigned MAX_WINDOW = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [srsw_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             start,
  output logic                             busy,
  input  srsw_pkg::srsw_item_t             item_i,
  output logic                             done_o,
  output srsw_pkg::srsw_result_t           result_o
);
  import srsw_pkg::*;

  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned IF_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IX_W  = ((SEQ_BITS > IF_W) ? SEQ_BITS : IF_W) + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RBASE, ST_RNEXT, ST_RSEQ, ST_OFF, ST_EXEC, ST_SLIDE, ST_RDMEM, ST_FIN
  } state_e;

  state_e                  state_q;
  logic [CFG_W-1:0]        seq_modulus_q;
  logic [3:0]              window_size_q;
  logic                    stale_q;
  srsw_item_t              item_q;
  srsw_result_t            res_q;
  logic                    done_q;
  logic [SEQ_BITS-1:0]     base_q;
  logic [SEQ_BITS-1:0]     next_q;
  logic [SEQ_BITS-1:0]     seqr_q;
  logic [SEQ_BITS-1:0]     off_q;
  logic [IF_W-1:0]         in_flight_q;
  logic [PTR_W-1:0]        hd_q;
  logic [MAX_WINDOW-1:0]   acked_q;
  logic [SEQ_BITS-1:0]     rem_q;
  logic [SEQ_BITS-1:0]     div_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [PAYLOAD_BITS-1:0] mem [MAX_WINDOW];
  logic [PAYLOAD_BITS-1:0] rd_q;

  logic [MOD_W-1:0]        m_eff;
  logic [MOD_W-1:0]        w_cmp;
  logic [IF_W-1:0]         w_eff;
  logic [MOD_W-1:0]        trial;
  logic [SEQ_BITS-1:0]     rem_d;
  logic                    mod_last;
  logic [MOD_W-1:0]        off_d;
  logic [IX_W-1:0]         off_sum;
  logic [IX_W-1:0]         snd_sum;
  logic [PTR_W-1:0]        off_idx;
  logic [PTR_W-1:0]        snd_idx;
  logic [PTR_W-1:0]        hd_d;
  logic                    off_hit;
  logic                    room;
  logic [SEQ_BITS-1:0]     base_d;
  logic [SEQ_BITS-1:0]     next_d;
  logic                    mem_we;

  always_comb begin
    m_eff = seq_modulus_q;
    if (seq_modulus_q < MOD_W'(2)) begin
      m_eff = MOD_W'(2);
    end else if (seq_modulus_q > SEQ_SPACE) begin
      m_eff = SEQ_SPACE;
    end
    w_cmp = MOD_W'(window_size_q);
    if (w_cmp < MOD_W'(1)) begin
      w_cmp = MOD_W'(1);
    end
    if (w_cmp > MOD_W'(MAX_WINDOW)) begin
      w_cmp = MOD_W'(MAX_WINDOW);
    end
    if (w_cmp > m_eff) begin
      w_cmp = m_eff;
    end
    w_eff = IF_W'(w_cmp);
  end

  assign trial    = {rem_q, div_q[SEQ_BITS-1]};
  assign rem_d    = (trial >= m_eff) ? SEQ_BITS'(trial - m_eff) : SEQ_BITS'(trial);
  assign mod_last = (cnt_q == CNT_W'(SEQ_BITS - 1));

  assign off_d = (seqr_q >= base_q) ? MOD_W'(seqr_q - base_q)
                                    : MOD_W'(seqr_q) + m_eff - MOD_W'(base_q);

  assign off_sum = IX_W'(hd_q) + IX_W'(off_q);
  assign snd_sum = IX_W'(hd_q) + IX_W'(in_flight_q);
  assign off_idx = (off_sum >= IX_W'(MAX_WINDOW)) ? PTR_W'(off_sum - IX_W'(MAX_WINDOW))
                                                  : PTR_W'(off_sum);
  assign snd_idx = (snd_sum >= IX_W'(MAX_WINDOW)) ? PTR_W'(snd_sum - IX_W'(MAX_WINDOW))
                                                  : PTR_W'(snd_sum);
  assign hd_d    = (hd_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : hd_q + 1'b1;

  assign off_hit = IX_W'(off_q) < IX_W'(in_flight_q);
  assign room    = in_flight_q < w_eff;
  assign base_d  = (MOD_W'(base_q) + 1'b1 == m_eff) ? '0 : base_q + 1'b1;
  assign next_d  = (MOD_W'(next_q) + 1'b1 == m_eff) ? '0 : next_q + 1'b1;

  assign mem_we = (state_q == ST_EXEC) && (item_q.cmd == CMD_SEND) && room;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[snd_idx] <= item_q.payload_in;
    end
    rd_q <= mem[off_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      seq_modulus_q <= SEQ_MODULUS_RST;
      window_size_q <= WINDOW_SIZE_RST;
      stale_q       <= 1'b0;
      done_q        <= 1'b0;
      base_q        <= '0;
      next_q        <= '0;
      in_flight_q   <= '0;
      hd_q          <= '0;
      acked_q       <= '0;
      cnt_q         <= '0;
    end else begin
      done_q <= (state_q == ST_FIN);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SEQ_MODULUS: seq_modulus_q <= cfg_data_i;
          CFG_WINDOW_SIZE: window_size_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (cfg_we_i && (cfg_idx_i == CFG_SEQ_MODULUS)) begin
        stale_q <= 1'b1;
      end else if ((state_q == ST_RNEXT) && mod_last) begin
        stale_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            item_q  <= item_i;
            res_q   <= '0;
            rem_q   <= '0;
            cnt_q   <= '0;
            div_q   <= stale_q ? base_q : item_i.seq_in;
            state_q <= stale_q ? ST_RBASE : ST_RSEQ;
          end
        end
        ST_RBASE, ST_RNEXT, ST_RSEQ: begin
          if (mod_last) begin
            rem_q <= '0;
            cnt_q <= '0;
            case (state_q)
              ST_RBASE: begin
                base_q  <= rem_d;
                div_q   <= next_q;
                state_q <= ST_RNEXT;
              end
              ST_RNEXT: begin
                next_q  <= rem_d;
                div_q   <= item_q.seq_in;
                state_q <= ST_RSEQ;
              end
              default: begin
                seqr_q  <= rem_d;
                state_q <= ST_OFF;
              end
            endcase
          end else begin
            rem_q <= rem_d;
            div_q <= {div_q[SEQ_BITS-2:0], 1'b0};
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_OFF: begin
          off_q   <= SEQ_BITS'(off_d);
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          case (item_q.cmd)
            CMD_SEND: begin
              state_q <= ST_FIN;
              if (room) begin
                acked_q[snd_idx]    <= 1'b0;
                in_flight_q         <= in_flight_q + 1'b1;
                next_q              <= next_d;
                res_q.accepted      <= 1'b1;
                res_q.tx_valid      <= 1'b1;
                res_q.tx_seq        <= next_q;
                res_q.tx_payload    <= item_q.payload_in;
                res_q.timer_start   <= 1'b1;
                res_q.timer_seq     <= next_q;
              end
            end
            CMD_ACK: begin
              if (item_q.checksum_ok && off_hit && !acked_q[off_idx]) begin
                acked_q[off_idx] <= 1'b1;
                res_q.accepted   <= 1'b1;
                res_q.timer_stop <= 1'b1;
                res_q.timer_seq  <= item_q.seq_in;
                state_q          <= ST_SLIDE;
              end else begin
                state_q <= ST_FIN;
              end
            end
            CMD_TIMEOUT: begin
              res_q.timer_stop <= 1'b1;
              res_q.timer_seq  <= item_q.seq_in;
              if (off_hit) begin
                res_q.accepted    <= 1'b1;
                res_q.tx_valid    <= 1'b1;
                res_q.tx_seq      <= seqr_q;
                res_q.timer_start <= 1'b1;
                state_q           <= ST_RDMEM;
              end else begin
                state_q <= ST_FIN;
              end
            end
            default: state_q <= ST_FIN;
          endcase
        end
        ST_SLIDE: begin
          if ((in_flight_q != '0) && acked_q[hd_q]) begin
            acked_q[hd_q] <= 1'b0;
            hd_q          <= hd_d;
            in_flight_q   <= in_flight_q - 1'b1;
            base_q        <= base_d;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_RDMEM: begin
          res_q.tx_payload <= rd_q;
          state_q          <= ST_FIN;
        end
        ST_FIN: begin
          res_q.window_full <= (in_flight_q >= w_eff);
          state_q           <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  a_in_flight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight_q <= IF_W'(MAX_WINDOW))
    else $error("in_flight exceeds the window storage");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command taken but sequencer did not go busy");

  a_base_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !stale_q) |-> (MOD_W'(base_q) < m_eff && MOD_W'(next_q) < m_eff))
    else $error("window base or next sequence number not reduced");

  a_tx_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.tx_valid) |-> (result_o.accepted && result_o.timer_start))
    else $error("packet sent without acceptance and timer start");

endmodule

[dv/selective_repeat_sender_window_tb.sv]
// Self-checking testbench for the selective-repeat sender window: directed and random beats.
module selective_repeat_sender_window_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srsw_pkg::*;

  localparam int SLOTS = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic start = 1'b0;
  logic busy;
  srsw_item_t item_i = '0;
  logic done_o;
  srsw_result_t result_o;

  selective_repeat_sender_window u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [6:0] cfg_modulus = 7'd8;
  logic [3:0] cfg_window = 4'd4;
  int win_base = 0;
  int next_sn = 0;
  int in_flight_n = 0;
  bit ack_mark [SLOTS];
  logic [PAYLOAD_BITS-1:0] slot_data [SLOTS];

  srsw_item_t pending_cmds [$];
  srsw_result_t expected_beats [$];
  int idle_pct = 22;
  bit beat_taken = 1'b0;
  int mismatches = 0;
  int beats_checked = 0;
  int sends_seen = 0;
  int acks_seen = 0;
  int resends_seen = 0;
  int cycles = 0;

  function automatic int eff_mod();
    int m;
    m = cfg_modulus;
    if (m < 2) m = 2;
    if (m > 64) m = 64;
    return m;
  endfunction

  function automatic int eff_win(int m);
    int w;
    w = cfg_window;
    if (w < 1) w = 1;
    if (w > SLOTS) w = SLOTS;
    if (w > m) w = m;
    return w;
  endfunction

  function automatic srsw_result_t window_step(srsw_item_t it);
    srsw_result_t r;
    int m, w, off, k;
    r = '0;
    m = eff_mod();
    w = eff_win(m);
    win_base = win_base % m;
    next_sn = next_sn % m;
    off = (int'(it.seq_in) + m - win_base) % m;
    case (it.cmd)
      CMD_SEND: begin
        if (in_flight_n < w) begin
          slot_data[in_flight_n] = it.payload_in;
          ack_mark[in_flight_n] = 1'b0;
          in_flight_n++;
          r.accepted = 1'b1;
          r.tx_valid = 1'b1;
          r.tx_seq = SEQ_BITS'(next_sn);
          r.tx_payload = it.payload_in;
          r.timer_start = 1'b1;
          r.timer_seq = SEQ_BITS'(next_sn);
          next_sn = (next_sn + 1) % m;
        end
      end
      CMD_ACK: begin
        if (it.checksum_ok && off < in_flight_n && !ack_mark[off]) begin
          ack_mark[off] = 1'b1;
          r.accepted = 1'b1;
          r.timer_stop = 1'b1;
          r.timer_seq = it.seq_in;
          while (in_flight_n > 0 && ack_mark[0]) begin
            for (k = 0; k < SLOTS - 1; k++) begin
              ack_mark[k] = ack_mark[k+1];
              slot_data[k] = slot_data[k+1];
            end
            ack_mark[SLOTS-1] = 1'b0;
            in_flight_n--;
            win_base = (win_base + 1) % m;
          end
        end
      end
      CMD_TIMEOUT: begin
        r.timer_stop = 1'b1;
        r.timer_seq = it.seq_in;
        if (off < in_flight_n) begin
          r.accepted = 1'b1;
          r.tx_valid = 1'b1;
          r.tx_seq = SEQ_BITS'((win_base + off) % m);
          r.tx_payload = slot_data[off];
          r.timer_start = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.window_full = (in_flight_n >= w);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!start || beat_taken)) begin
      beat_taken = 1'b0;
      if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        item_i <= pending_cmds[0];
        pending_cmds.delete(0);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    srsw_result_t want;
    srsw_result_t pred;
    if (rst_ni) begin
      if (done_o !== 1'b0) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing outstanding, got %0h", $time, result_o);
        end else begin
          want = expected_beats[0];
          expected_beats.delete(0);
          check_field("accepted", 32'(want.accepted), 32'(result_o.accepted));
          check_field("window_full", 32'(want.window_full), 32'(result_o.window_full));
          check_field("tx_valid", 32'(want.tx_valid), 32'(result_o.tx_valid));
          check_field("tx_seq", 32'(want.tx_seq), 32'(result_o.tx_seq));
          check_field("tx_payload", 32'(want.tx_payload), 32'(result_o.tx_payload));
          check_field("timer_start", 32'(want.timer_start), 32'(result_o.timer_start));
          check_field("timer_stop", 32'(want.timer_stop), 32'(result_o.timer_stop));
          check_field("timer_seq", 32'(want.timer_seq), 32'(result_o.timer_seq));
          beats_checked++;
          if (want.accepted && want.timer_start && !want.timer_stop) sends_seen++;
          if (want.accepted && want.timer_stop && !want.tx_valid) acks_seen++;
          if (want.accepted && want.tx_valid && want.timer_stop) resends_seen++;
        end
      end
      if (start && !busy) begin
        pred = window_step(item_i);
        expected_beats = {expected_beats, pred};
        beat_taken = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_cmd(logic [1:0] c, int s, bit ck, logic [31:0] p);
    srsw_item_t it;
    it.cmd = c;
    it.seq_in = SEQ_BITS'(s);
    it.checksum_ok = ck;
    it.payload_in = p;
    pending_cmds = {pending_cmds, it};
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start || expected_beats.size() != 0 || busy)
      @(negedge clk_i);
  endtask

  task automatic run_phase(bit wr, logic [6:0] mod, logic [6:0] win, int n, int idle);
    srsw_item_t it;
    int m, w, r, s, i;
    if (wr) begin
      wait_idle();
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CFG_SEQ_MODULUS;
      cfg_data_i <= mod;
      @(negedge clk_i);
      cfg_idx_i <= CFG_WINDOW_SIZE;
      cfg_data_i <= win;
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      cfg_modulus = mod;
      cfg_window = win[3:0];
    end
    idle_pct = idle;
    for (i = 0; i < n; i++) begin
      while (pending_cmds.size() > 1) begin
        @(posedge clk_i);
        #1;
      end
      m = eff_mod();
      w = eff_win(m);
      it.cmd = CMD_SEND;
      it.seq_in = SEQ_BITS'($urandom_range(63));
      it.checksum_ok = 1'b1;
      it.payload_in = $urandom();
      r = $urandom_range(99);
      if (r < 4) it.payload_in = '0;
      else if (r < 8) it.payload_in = '1;
      r = $urandom_range(99);
      if (r < 15) begin
        it.cmd = 2'($urandom_range(3));
        it.checksum_ok = 1'($urandom_range(1));
      end else if (in_flight_n == 0 || (in_flight_n < w && r < 55)) begin
        it.cmd = CMD_SEND;
      end else begin
        s = $urandom_range(1) ? 0 : $urandom_range(in_flight_n - 1);
        s = (win_base + s) % m;
        if ($urandom_range(9) == 0 && s + m < 64) s += m;
        it.seq_in = SEQ_BITS'(s);
        it.cmd = (r < 85) ? CMD_ACK : CMD_TIMEOUT;
      end
      pending_cmds = {pending_cmds, it};
    end
  endtask

  initial begin
    foreach (ack_mark[k]) begin
      ack_mark[k] = 1'b0;
      slot_data[k] = '0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_cmd(CMD_SEND, 0, 1'b1, 32'h0000_0000);
    push_cmd(CMD_SEND, 0, 1'b0, 32'hFFFF_FFFF);
    push_cmd(CMD_SEND, 63, 1'b1, 32'hA5A5_A5A5);
    push_cmd(CMD_SEND, 0, 1'b1, 32'h5A5A_5A5A);
    push_cmd(CMD_SEND, 0, 1'b1, 32'h0000_1234);
    push_cmd(CMD_ACK, 1, 1'b0, 32'h0);
    push_cmd(CMD_ACK, 5, 1'b1, 32'h0);
    push_cmd(CMD_ACK, 1, 1'b1, 32'h0);
    push_cmd(CMD_ACK, 1, 1'b1, 32'h0);
    push_cmd(CMD_TIMEOUT, 2, 1'b1, 32'h0);
    push_cmd(CMD_TIMEOUT, 6, 1'b1, 32'h0);
    push_cmd(CMD_TIMEOUT, 58, 1'b0, 32'h0);
    push_cmd(2'd3, 63, 1'b1, 32'hFFFF_FFFF);
    push_cmd(CMD_ACK, 0, 1'b1, 32'h0);
    push_cmd(CMD_ACK, 59, 1'b1, 32'h0);
    push_cmd(CMD_ACK, 2, 1'b1, 32'h0);
    push_cmd(CMD_TIMEOUT, 4, 1'b1, 32'h0);
    push_cmd(CMD_SEND, 0, 1'b1, 32'hDEAD_0001);

    run_phase(1'b0, 7'd8, 7'd4, 230, 22);
    run_phase(1'b1, 7'd2, 7'd8, 200, 22);
    run_phase(1'b1, 7'd64, 7'd8, 250, 22);
    run_phase(1'b1, 7'd0, 7'd0, 150, 50);
    run_phase(1'b1, 7'h7F, 7'h7F, 200, 50);
    run_phase(1'b1, 7'd5, 7'd3, 200, 50);
    run_phase(1'b1, 7'd33, 7'd7, 200, 0);
    run_phase(1'b1, 7'd16, 7'd1, 120, 0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Checked %0d result beats across 8 modulus/window settings.", beats_checked);
    $display("Covered %0d sends, %0d acks taken and %0d retransmits.",
             sends_seen, acks_seen, resends_seen);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[selective_repeat_sender_window.f]
rtl/srsw_pkg.sv
rtl/selective_repeat_sender_window.sv
dv/selective_repeat_sender_window_tb.sv
